// ===== src/ermm_pkg.sv =====
// Package for the running min/max/mean statistics engine.
// Holds the beat types, the op codes, the divider width and the controller states; no dependencies.
`timescale 1ns / 1ps
package ermm_pkg;

  localparam int DIV_W = 48;
  localparam logic [15:0] PASS_LIMIT = 16'hFFFF;
  localparam logic OP_SAMPLE = 1'b0;
  localparam logic OP_CLEAR  = 1'b1;

  typedef struct packed {
    logic               op;
    logic [2:0]         layer;
    logic [9:0]         element;
    logic signed [15:0] value;
    logic               first_sample;
    logic               last_sample;
  } ermm_in_t;

  typedef struct packed {
    logic [2:0]         out_layer;
    logic [9:0]         out_element;
    logic signed [15:0] overall_max;
    logic signed [15:0] overall_min;
    logic signed [31:0] running_mean;
    logic [15:0]        pass_count;
  } ermm_out_t;

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_READ,
    ST_DIV_MEAN,
    ST_DIV_UPD,
    ST_COMMIT,
    ST_EMIT
  } ermm_state_t;

endpackage

// ===== src/ermm_ram.sv =====
// Single-port-write, single-port-read synchronous memory with registered read data.
// No dependencies.
`timescale 1ns / 1ps
module ermm_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 8192,
  parameter int AW    = 13
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic             re,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// ===== src/ermm_div.sv =====
// Bit-serial signed divider, truncating toward zero, one quotient bit per cycle.
// Depends on ermm_pkg for the dividend width.
`timescale 1ns / 1ps
module ermm_div (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               start,
  input  logic signed [ermm_pkg::DIV_W-1:0]  dividend,
  input  logic [15:0]                        divisor,
  output logic                               done,
  output logic signed [ermm_pkg::DIV_W-1:0]  quotient
);
  import ermm_pkg::*;

  localparam int CNT_W = $clog2(DIV_W);

  logic [DIV_W-1:0] q;
  logic [15:0]      rem;
  logic [15:0]      dvs;
  logic [CNT_W-1:0] cnt;
  logic             busy;
  logic             neg;
  logic [16:0]      rem_sh;
  logic             ge;
  logic [16:0]      rem_next;

  assign rem_sh   = {rem, q[DIV_W-1]};
  assign ge       = rem_sh >= {1'b0, dvs};
  assign rem_next = ge ? (rem_sh - {1'b0, dvs}) : rem_sh;
  assign quotient = neg ? -$signed(q) : $signed(q);

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
      end else if (busy && cnt == CNT_W'(DIV_W - 1)) begin
        busy <= 1'b0;
        done <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      q   <= dividend[DIV_W-1] ? DIV_W'(-dividend) : DIV_W'(dividend);
      neg <= dividend[DIV_W-1];
      rem <= '0;
      dvs <= divisor;
      cnt <= '0;
    end else if (busy) begin
      q   <= {q[DIV_W-2:0], ge};
      rem <= rem_next[15:0];
      cnt <= cnt + 1'b1;
    end
  end

endmodule

// ===== src/elementwise_running_min_max_mean.sv =====
// Top level of the per-element running min/max/mean statistics engine.
// Depends on ermm_pkg, ermm_ram and ermm_div.
`timescale 1ns / 1ps
//
// Channel  Direction  Handshake                    Beat
// sample   in         sample_valid / sample_stall  ermm_in_t
// result   out        result_valid / result_stall  ermm_out_t
//
// A sample that does not commit passes through the memory read, then the batch write.
// A committing sample adds two passes through the serial divider (one on a slot's
// first pass), then the commit state and the output state.
// After reset and after each clear op the pass counts are swept, one slot a cycle,
// over all LAYERS * ELEMENTS slots, while sample_stall stays high.
// A finished result waits in the output register while the next sample is taken.
module elementwise_running_min_max_mean #(
  parameter int LAYERS    = 8,
  parameter int ELEMENTS  = 1024,
  parameter int MAX_BATCH = 256
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                sample_valid,
  output logic                sample_stall,
  input  ermm_pkg::ermm_in_t  sample,
  output logic                result_valid,
  input  logic                result_stall,
  output ermm_pkg::ermm_out_t result
);
  import ermm_pkg::*;

  localparam int SLOTS = LAYERS * ELEMENTS;
  localparam int AW    = (SLOTS > 1) ? $clog2(SLOTS) : 1;
  localparam int CW    = $clog2(MAX_BATCH + 1);
  localparam int SW    = 16 + CW;
  localparam int BW    = 32 + SW + CW;
  localparam int RW    = 64;

  ermm_state_t state, state_next;

  ermm_in_t         item;
  logic [AW-1:0]    slot;
  logic [AW-1:0]    clr_cnt;
  logic [AW-1:0]    in_slot;
  logic             in_range;
  logic             accept;
  logic             out_free;

  logic [BW-1:0]    b_rdata;
  logic [BW-1:0]    b_wdata;
  logic [RW-1:0]    r_rdata;
  logic [15:0]      p_rdata;
  logic             b_we;
  logic             r_we;
  logic             p_we;
  logic             rd_en;
  logic [AW-1:0]    p_waddr;
  logic [15:0]      p_wdata;

  logic signed [15:0]   b_max, b_min, bt_max, bt_min, n_max, n_min;
  logic signed [SW-1:0] b_sum, n_sum;
  logic [CW-1:0]        b_cnt, n_cnt;
  logic                 room;
  logic signed [15:0]   r_max, r_min;
  logic signed [31:0]   r_mean;

  logic signed [15:0] res_max, res_min;
  logic signed [31:0] res_mean;
  logic [15:0]        res_pass;

  logic                     div_start;
  logic signed [DIV_W-1:0]  div_dividend;
  logic [15:0]              div_divisor;
  logic                     div_done;
  logic signed [DIV_W-1:0]  div_q;
  logic [15:0]              pass_inc;

  assign in_slot  = AW'(32'(sample.layer) * ELEMENTS + 32'(sample.element));
  assign in_range = (32'(sample.layer) < LAYERS) && (32'(sample.element) < ELEMENTS);
  assign accept   = sample_valid && !sample_stall;
  assign out_free = !result_valid || !result_stall;

  assign {b_max, b_min, b_sum, b_cnt} = b_rdata;
  assign {r_max, r_min, r_mean}       = r_rdata;

  assign room  = 32'(b_cnt) < MAX_BATCH;
  always_comb begin
    if (item.first_sample) begin
      n_max = item.value;
      n_min = item.value;
      n_sum = SW'(item.value);
      n_cnt = CW'(1);
    end else if (room) begin
      n_max = (item.value > b_max) ? item.value : b_max;
      n_min = (item.value < b_min) ? item.value : b_min;
      n_sum = b_sum + SW'(item.value);
      n_cnt = b_cnt + 1'b1;
    end else begin
      n_max = b_max;
      n_min = b_min;
      n_sum = b_sum;
      n_cnt = b_cnt;
    end
  end
  assign b_wdata  = {n_max, n_min, n_sum, n_cnt};
  assign pass_inc = (p_rdata == PASS_LIMIT) ? PASS_LIMIT : p_rdata + 1'b1;

  always_comb begin
    state_next = state;
    unique case (state)
      ST_CLEAR: begin
        if (clr_cnt == AW'(SLOTS - 1)) state_next = ST_IDLE;
      end
      ST_IDLE: begin
        if (accept) begin
          if (sample.op == OP_CLEAR) state_next = ST_CLEAR;
          else if (in_range) state_next = ST_READ;
        end
      end
      ST_READ: begin
        state_next = item.last_sample ? ST_DIV_MEAN : ST_IDLE;
      end
      ST_DIV_MEAN: begin
        if (div_done) state_next = (p_rdata == '0) ? ST_COMMIT : ST_DIV_UPD;
      end
      ST_DIV_UPD: begin
        if (div_done) state_next = ST_COMMIT;
      end
      ST_COMMIT: state_next = ST_EMIT;
      ST_EMIT: begin
        if (out_free) state_next = ST_IDLE;
      end
      default: state_next = ST_IDLE;
    endcase
  end

  always_comb begin
    sample_stall = state != ST_IDLE;
    rd_en        = state == ST_IDLE && accept;
    b_we         = state == ST_READ;
    r_we         = state == ST_COMMIT;
    p_we         = state == ST_COMMIT || state == ST_CLEAR;
    p_waddr      = (state == ST_CLEAR) ? clr_cnt : slot;
    p_wdata      = (state == ST_CLEAR) ? 16'd0 : res_pass;
    div_start    = 1'b0;
    div_dividend = DIV_W'(n_sum) <<< 8;
    div_divisor  = 16'(n_cnt);
    unique case (state)
      ST_READ: div_start = item.last_sample;
      ST_DIV_MEAN: begin
        div_start    = div_done && p_rdata != '0;
        div_dividend = div_q - DIV_W'(r_mean);
        div_divisor  = pass_inc;
      end
      default: div_start = 1'b0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state   <= ST_CLEAR;
      clr_cnt <= '0;
    end else begin
      state <= state_next;
      if (state == ST_CLEAR) clr_cnt <= clr_cnt + 1'b1;
      else clr_cnt <= '0;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      item <= sample;
      slot <= in_slot;
    end
    if (state == ST_READ) begin
      bt_max <= n_max;
      bt_min <= n_min;
    end
    if (state == ST_DIV_MEAN && div_done) begin
      if (p_rdata == '0) begin
        res_max  <= bt_max;
        res_min  <= bt_min;
        res_mean <= div_q[31:0];
        res_pass <= 16'd1;
      end else begin
        res_max  <= (bt_max > r_max) ? bt_max : r_max;
        res_min  <= (bt_min < r_min) ? bt_min : r_min;
        res_mean <= r_mean;
        res_pass <= pass_inc;
      end
    end
    if (state == ST_DIV_UPD && div_done) begin
      res_mean <= res_mean + div_q[31:0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else begin
      if (result_valid && !result_stall) result_valid <= 1'b0;
      if (state == ST_EMIT && out_free) result_valid <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (state == ST_EMIT && out_free) begin
      result.out_layer    <= item.layer;
      result.out_element  <= item.element;
      result.overall_max  <= res_max;
      result.overall_min  <= res_min;
      result.running_mean <= res_mean;
      result.pass_count   <= res_pass;
    end
  end

  ermm_ram #(.WIDTH(BW), .DEPTH(SLOTS), .AW(AW)) u_batch_ram (
    .clk   (clk),
    .we    (b_we),
    .waddr (slot),
    .wdata (b_wdata),
    .re    (rd_en),
    .raddr (in_slot),
    .rdata (b_rdata)
  );

  ermm_ram #(.WIDTH(RW), .DEPTH(SLOTS), .AW(AW)) u_run_ram (
    .clk   (clk),
    .we    (r_we),
    .waddr (slot),
    .wdata ({res_max, res_min, res_mean}),
    .re    (rd_en),
    .raddr (in_slot),
    .rdata (r_rdata)
  );

  ermm_ram #(.WIDTH(16), .DEPTH(SLOTS), .AW(AW)) u_pass_ram (
    .clk   (clk),
    .we    (p_we),
    .waddr (p_waddr),
    .wdata (p_wdata),
    .re    (rd_en),
    .raddr (in_slot),
    .rdata (p_rdata)
  );

  ermm_div u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (div_start),
    .dividend (div_dividend),
    .divisor  (div_divisor),
    .done     (div_done),
    .quotient (div_q)
  );

endmodule
